// ===== src/vrp_pkg.sv =====
`timescale 1ns / 1ps

package vrp_pkg;

   // Field widths
   localparam int CoordW = 16;             // Q11.4 vertex coordinate
   localparam int TrigW  = 16;             // Q1.14 cosine / sine
   localparam int EyeW   = 15;             // Q11.4 eye distance
   localparam int ScaleW = 8;              // Q4.4 screen scale
   localparam int PixW   = 16;             // signed pixel result

   // Datapath widths
   localparam int ProdW  = CoordW + TrigW;        // one rotation product
   localparam int RotW   = ProdW + 1;             // rotated coordinate, 2^-18 units
   localparam int DenW   = RotW + 1;              // denominator, 2^-18 units
   localparam int KW     = EyeW + ScaleW;         // eye_distance * screen_scale
   localparam int LoW    = 16;                    // low split of rotated x
   localparam int HiW    = RotW - LoW;            // high split of rotated x
   localparam int PpLoW  = KW + LoW;              // unsigned low partial product
   localparam int PpHiW  = KW + 1 + HiW;          // signed high partial product
   localparam int KyW    = KW + 1 + CoordW;       // k * y
   localparam int NumW   = PpHiW + LoW;           // signed numerator
   localparam int MagW   = NumW - 1;              // numerator magnitude
   localparam int DsrW   = DenW + 8;              // divisor, den * 256
   localparam int QuoW   = 16;                    // quotient bits kept
   localparam int QuoSteps = QuoW + 1;            // range check plus one bit each
   localparam int DivW   = MagW + 2;              // compare width in the divider

   // Register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CsrCos   = 2'd0;
   localparam csr_index_type CsrSin   = 2'd1;
   localparam csr_index_type CsrEye   = 2'd2;
   localparam csr_index_type CsrScale = 2'd3;

   // Register reset values
   localparam logic signed [TrigW-1:0] CosReset   = 16'sd16384;
   localparam logic signed [TrigW-1:0] SinReset   = 16'sd0;
   localparam logic [EyeW-1:0]         EyeReset   = 15'd800;
   localparam logic [ScaleW-1:0]       ScaleReset = 8'd128;

   // Saturation limits
   localparam logic [PixW-1:0] PixMax = 16'h7FFF;
   localparam logic [PixW-1:0] PixMin = 16'h8000;

   // One divider lane
   typedef struct packed {
      logic [MagW-1:0] rem;
      logic [QuoW-1:0] quo;
      logic            neg;
      logic            ovf;
   } lane_type;

   // One divider stage: both lanes share the divisor
   typedef struct packed {
      lane_type        lx;
      lane_type        ly;
      logic [DsrW-1:0] dsr;
      logic            behind;
   } div_stage_type;

endpackage

// ===== src/vertex_rotate_project.sv =====
`timescale 1ns / 1ps

// Rotates a Q11.4 vertex about the Y axis and projects it to screen pixels.
// Input: a vertex word is taken at a rising edge with start high and busy low.
// busy is low at all times except while reset is held, so a new vertex may be
// started in every cycle. Results leave on rsp_* for exactly one cycle, marked
// by rsp_valid, in the order the vertices came in; the receiver cannot stall.
// Throughput is one vertex per cycle. The depth of the pipeline comes from
// the four-step multiply front end and the restoring divider, which produces
// one quotient bit per stage (a range check plus sixteen bits).
// Configuration: csr_we writes csr_wdata into register csr_index (0 cosine,
// 1 sine, 2 eye distance, 3 screen scale) at the clock edge. Rewrite only
// while no vertex is in flight; the product eye*scale is registered and
// follows a write in the next cycle.
// Reset: synchronous, clears every valid bit in the pipeline and loads the
// register defaults (identity rotation, eye 50.0, scale 8.0).
module vertex_rotate_project (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [vrp_pkg::CoordW-1:0]     req_vertex_x,
   input  logic signed [vrp_pkg::CoordW-1:0]     req_vertex_y,
   input  logic signed [vrp_pkg::CoordW-1:0]     req_vertex_z,
   output logic                                  rsp_valid,
   output logic signed [vrp_pkg::PixW-1:0]       rsp_screen_x,
   output logic signed [vrp_pkg::PixW-1:0]       rsp_screen_y,
   output logic                                  rsp_behind_eye,
   output logic                                  rsp_clipped,
   input  logic                                  csr_we,
   input  vrp_pkg::csr_index_type                csr_index,
   input  logic [vrp_pkg::TrigW-1:0]             csr_wdata
);
   import vrp_pkg::*;

   // Configuration registers
   logic signed [TrigW-1:0] cos_ff;
   logic signed [TrigW-1:0] sin_ff;
   logic [EyeW-1:0]         eye_ff;
   logic [ScaleW-1:0]       scale_ff;
   logic [KW-1:0]           k_ff;

   // Stage 1: rotation products
   logic                    v1_ff;
   logic signed [ProdW-1:0] xc_ff, zs_ff, zc_ff, xs_ff;
   logic signed [CoordW-1:0] y1_ff;

   // Stage 2: rotated coordinates
   logic                    v2_ff;
   logic signed [RotW-1:0]  rx_ff, rz_ff;
   logic signed [CoordW-1:0] y2_ff;

   // Stage 3: denominator and scaled partial products
   logic                    v3_ff;
   logic signed [DenW-1:0]  den_ff;
   logic [PpLoW-1:0]        pplo_ff;
   logic signed [PpHiW-1:0] pphi_ff;
   logic signed [KyW-1:0]   ky_ff;

   // Stage 4: numerators and divisor
   logic                    v4_ff;
   logic signed [NumW-1:0]  numx_ff, numy_ff;
   logic [DsrW-1:0]         dsr_ff;
   logic                    behind4_ff;

   // Divider stages; entry 0 is loaded from stage 4
   logic                    dv_ff [0:QuoSteps];
   div_stage_type           div_ff [0:QuoSteps];
   div_stage_type           div_in [0:QuoSteps-1];
   div_stage_type           div_ld_in;

   // Output register
   logic                    out_v_ff;
   logic [PixW-1:0]         out_x_ff, out_y_ff;
   logic                    out_behind_ff, out_clip_ff;
   logic [PixW-1:0]         out_x_in, out_y_in;
   logic                    out_clip_in;
   logic                    clip_x, clip_y;

   logic                    accept;
   logic signed [NumW-1:0]  negx, negy;

   assign busy   = reset;
   assign accept = start & ~busy;

   // One restoring step; a range-check step only flags overflow
   function automatic lane_type div_step(input lane_type cur,
                                         input logic [DivW-1:0] dsh,
                                         input logic chk_only,
                                         input logic [QuoW-1:0] bit_mask);
      lane_type     nxt;
      logic [DivW:0] diff;
      nxt  = cur;
      diff = {3'b000, cur.rem} - {1'b0, dsh};
      if (!diff[DivW]) begin
         if (chk_only) begin
            nxt.ovf = 1'b1;
         end else begin
            nxt.rem = diff[MagW-1:0];
            nxt.quo = cur.quo | bit_mask;
         end
      end
      return nxt;
   endfunction

   // Saturate one lane to signed pixels
   function automatic logic [PixW:0] sat_lane(input lane_type ln);
      logic [PixW-1:0] val;
      logic            clip;
      clip = 1'b0;
      if (ln.neg) begin
         if (ln.ovf || (ln.quo > PixMin)) begin
            val  = PixMin;
            clip = 1'b1;
         end else begin
            val = ~ln.quo + 1'b1;
         end
      end else begin
         if (ln.ovf || ln.quo[QuoW-1]) begin
            val  = PixMax;
            clip = 1'b1;
         end else begin
            val = ln.quo;
         end
      end
      return {clip, val};
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff   <= CosReset;
         sin_ff   <= SinReset;
         eye_ff   <= EyeReset;
         scale_ff <= ScaleReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrCos:   cos_ff   <= csr_wdata;
            CsrSin:   sin_ff   <= csr_wdata;
            CsrEye:   eye_ff   <= csr_wdata[EyeW-1:0];
            CsrScale: scale_ff <= csr_wdata[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   // Constant scale factor, eye * scale
   always_ff @(posedge clock) begin
      k_ff <= eye_ff * scale_ff;
   end

   // Valid bits of the front end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Front end payload
   always_ff @(posedge clock) begin
      // stage 1: four 16x16 products
      xc_ff <= req_vertex_x * cos_ff;
      zs_ff <= req_vertex_z * sin_ff;
      zc_ff <= req_vertex_z * cos_ff;
      xs_ff <= req_vertex_x * sin_ff;
      y1_ff <= req_vertex_y;
      // stage 2: rx = x*cos + z*sin, rz = z*cos - x*sin
      rx_ff <= {xc_ff[ProdW-1], xc_ff} + {zs_ff[ProdW-1], zs_ff};
      rz_ff <= {zc_ff[ProdW-1], zc_ff} - {xs_ff[ProdW-1], xs_ff};
      y2_ff <= y1_ff;
      // stage 3: den = eye * 2^14 - rz, and k times numerators
      den_ff  <= $signed({{(DenW-EyeW-14){1'b0}}, eye_ff, 14'b0})
               - {rz_ff[RotW-1], rz_ff};
      pplo_ff <= k_ff * rx_ff[LoW-1:0];
      pphi_ff <= $signed({1'b0, k_ff}) * $signed(rx_ff[RotW-1:LoW]);
      ky_ff   <= $signed({1'b0, k_ff}) * y2_ff;
      // stage 4: assemble numerators, divisor is den * 256
      numx_ff    <= $signed({pphi_ff, {LoW{1'b0}}})
                  + $signed({{(NumW-PpLoW){1'b0}}, pplo_ff});
      numy_ff    <= {{(NumW-KyW-14){ky_ff[KyW-1]}}, ky_ff, 14'b0};
      dsr_ff     <= {den_ff, 8'b0};
      behind4_ff <= den_ff[DenW-1] | (den_ff == '0);
   end

   // Stage 5: split numerators into sign and magnitude
   always_comb begin
      negx = -numx_ff;
      negy = -numy_ff;
      div_ld_in.lx.neg = numx_ff[NumW-1];
      div_ld_in.lx.rem = numx_ff[NumW-1] ? negx[MagW-1:0] : numx_ff[MagW-1:0];
      div_ld_in.lx.quo = '0;
      div_ld_in.lx.ovf = 1'b0;
      div_ld_in.ly.neg = numy_ff[NumW-1];
      div_ld_in.ly.rem = numy_ff[NumW-1] ? negy[MagW-1:0] : numy_ff[MagW-1:0];
      div_ld_in.ly.quo = '0;
      div_ld_in.ly.ovf = 1'b0;
      div_ld_in.dsr    = dsr_ff;
      div_ld_in.behind = behind4_ff;
   end

   // Divider steps: the first checks the quotient range, then one bit each
   always_comb begin
      logic [DivW-1:0] dsh;
      logic [QuoW-1:0] mask;
      for (int j = 0; j < QuoSteps; j++) begin
         dsh  = DivW'(div_ff[j].dsr) << (QuoW - j);
         mask = QuoW'(1) << (QuoW - j);
         div_in[j]    = div_ff[j];
         div_in[j].lx = div_step(div_ff[j].lx, dsh, (j == 0), mask);
         div_in[j].ly = div_step(div_ff[j].ly, dsh, (j == 0), mask);
      end
   end

   // Divider valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QuoSteps; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else begin
         dv_ff[0] <= v4_ff;
         for (int j = 0; j < QuoSteps; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
   end

   // Divider payload
   always_ff @(posedge clock) begin
      div_ff[0] <= div_ld_in;
      for (int j = 0; j < QuoSteps; j++) begin
         div_ff[j+1] <= div_in[j];
      end
   end

   // Saturation and behind-eye masking
   always_comb begin
      {clip_x, out_x_in} = sat_lane(div_ff[QuoSteps].lx);
      {clip_y, out_y_in} = sat_lane(div_ff[QuoSteps].ly);
      out_clip_in = clip_x | clip_y;
      if (div_ff[QuoSteps].behind) begin
         out_x_in    = '0;
         out_y_in    = '0;
         out_clip_in = 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dv_ff[QuoSteps];
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_behind_ff <= div_ff[QuoSteps].behind;
      out_clip_ff   <= out_clip_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_screen_x   = out_x_ff;
   assign rsp_screen_y   = out_y_ff;
   assign rsp_behind_eye = out_behind_ff;
   assign rsp_clipped    = out_clip_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// One screen word as the block should present it
typedef struct packed {
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic               behind_eye;
   logic               clipped;
} pixel_word_type;

class projection_scoreboard;
   // shadow copy of the block's registers
   logic signed [vrp_pkg::TrigW-1:0] cos_q;
   logic signed [vrp_pkg::TrigW-1:0] sin_q;
   logic [vrp_pkg::EyeW-1:0]         eye_q;
   logic [vrp_pkg::ScaleW-1:0]       scale_q;

   pixel_word_type pending_pixels[$];
   int mismatches;
   int pixels_checked;
   int behind_count;
   int clipped_count;

   function new();
      cos_q = vrp_pkg::CosReset;
      sin_q = vrp_pkg::SinReset;
      eye_q = vrp_pkg::EyeReset;
      scale_q = vrp_pkg::ScaleReset;
      mismatches = 0;
      pixels_checked = 0;
      behind_count = 0;
      clipped_count = 0;
   endfunction

   function void write_reg(vrp_pkg::csr_index_type idx, logic [15:0] data);
      case (idx)
         vrp_pkg::CsrCos:   cos_q = data;
         vrp_pkg::CsrSin:   sin_q = data;
         vrp_pkg::CsrEye:   eye_q = data[vrp_pkg::EyeW-1:0];
         vrp_pkg::CsrScale: scale_q = data[vrp_pkg::ScaleW-1:0];
         default: ;
      endcase
   endfunction

   // Rotate about Y, project, scale; everything exact in 2^-18 units,
   // one truncation toward zero at the end
   function pixel_word_type project_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                           logic signed [15:0] vz);
      longint rx;
      longint ry;
      longint rz;
      longint den;
      longint k;
      longint q[2];
      pixel_word_type w;
      rx = longint'(vx) * longint'(cos_q) + longint'(vz) * longint'(sin_q);
      ry = longint'(vy) * 16384;
      rz = longint'(vz) * longint'(cos_q) - longint'(vx) * longint'(sin_q);
      den = longint'(eye_q) * 16384 - rz;
      w = '0;
      if (den <= 0) begin
         // behind the eye: coordinates forced to zero
         w.behind_eye = 1'b1;
      end else begin
         k = longint'(eye_q) * longint'(scale_q);
         q[0] = (k * rx) / (den * 256);
         q[1] = (k * ry) / (den * 256);
         for (int i = 0; i < 2; i++) begin
            if (q[i] > 32767) begin
               q[i] = 32767;
               w.clipped = 1'b1;
            end else if (q[i] < -32768) begin
               q[i] = -32768;
               w.clipped = 1'b1;
            end
         end
         w.screen_x = q[0][15:0];
         w.screen_y = q[1][15:0];
      end
      return w;
   endfunction

   function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] vz);
      pending_pixels.push_back(project_vertex(vx, vy, vz));
   endfunction

   function void check_pixel(pixel_word_type got);
      pixel_word_type want;
      if (pending_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: screen word with none pending: x=%0d y=%0d behind=%0b clip=%0b",
                     $realtime, got.screen_x, got.screen_y, got.behind_eye, got.clipped);
         return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (want.behind_eye) behind_count++;
      if (want.clipped) clipped_count++;
      if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
          got.behind_eye !== want.behind_eye || got.clipped !== want.clipped) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"%0t: word %0d exp x=%0d y=%0d behind=%0b clip=%0b,",
                      " got x=%0d y=%0d behind=%0b clip=%0b"},
                     $realtime, pixels_checked, want.screen_x, want.screen_y,
                     want.behind_eye, want.clipped, got.screen_x, got.screen_y,
                     got.behind_eye, got.clipped);
      end
   endfunction
endclass

module testbench;

   localparam int StallLimit    = 1000;
   localparam int ItemsPerPhase = 150;
   localparam int NumPhases     = 8;
   localparam int QuietPhase    = 2;   // no sender gaps at all
   localparam int HoldPhase     = 3;   // sender stops mid-phase until drained

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_vertex_x = '0;
   logic signed [15:0] req_vertex_y = '0;
   logic signed [15:0] req_vertex_z = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic rsp_behind_eye;
   logic rsp_clipped;
   logic csr_we = 1'b0;
   vrp_pkg::csr_index_type csr_index = vrp_pkg::CsrCos;
   logic [15:0] csr_wdata = '0;

   projection_scoreboard sb = new();
   pixel_word_type rsp_word;
   int vertices_accepted = 0;
   int stall_cycles = 0;
   int settings_applied = 0;

   always #5 clock = ~clock;

   vertex_rotate_project i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_vertex_x   (req_vertex_x),
      .req_vertex_y   (req_vertex_y),
      .req_vertex_z   (req_vertex_z),
      .rsp_valid      (rsp_valid),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_behind_eye (rsp_behind_eye),
      .rsp_clipped    (rsp_clipped),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Handshake monitor: note accepted vertex words, check screen words
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_vertex(req_vertex_x, req_vertex_y, req_vertex_z);
         vertices_accepted++;
      end
      if (!reset && rsp_valid) begin
         rsp_word.screen_x = rsp_screen_x;
         rsp_word.screen_y = rsp_screen_y;
         rsp_word.behind_eye = rsp_behind_eye;
         rsp_word.clipped = rsp_clipped;
         sb.check_pixel(rsp_word);
      end
      if (!reset && ((start && !busy) || rsp_valid)) stall_cycles = 0;
      else stall_cycles++;
   end

   // Watchdog
   initial begin
      wait (stall_cycles >= StallLimit);
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("vertex_rotate_project: mismatch");
      $finish;
   end

   task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
      @(negedge clock);
      start <= 1'b1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_vertex_z <= z;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      pause_sender(1);
      while (sb.pending_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input vrp_pkg::csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
   endtask

   // Register writes happen only with the pipeline empty
   task automatic configure(input logic [15:0] cos_w, input logic [15:0] sin_w,
                            input logic [15:0] eye_w, input logic [15:0] scale_w);
      wait_drained();
      write_csr(vrp_pkg::CsrCos, cos_w);
      write_csr(vrp_pkg::CsrSin, sin_w);
      write_csr(vrp_pkg::CsrEye, eye_w);
      write_csr(vrp_pkg::CsrScale, scale_w);
      @(negedge clock);
      csr_we <= 1'b0;
      // let the registered eye*scale product catch up with the last write
      @(negedge clock);
      settings_applied++;
   endtask

   task automatic send_corners();
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh8000);
      send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF);
      send_vertex(0, 0, 0);
      send_vertex(160, 160, -160);
   endtask

   function automatic logic signed [15:0] corner_value();
      case ($urandom_range(0, 3))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   task automatic pick_vertex(output logic signed [15:0] x, output logic signed [15:0] y,
                              output logic signed [15:0] z);
      longint zt;
      int span;
      span = int'(sb.eye_q) / 2 + 16;
      case ($urandom_range(0, 9))
         0, 1: begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
         end
         2: begin
            x = corner_value();
            y = corner_value();
            z = corner_value();
         end
         3: begin
            // aim z*cos at eye*2^14 so the denominator lands near zero
            x = 0;
            y = 16'(int'($urandom_range(0, 2 * span)) - span);
            if (sb.cos_q == 0) begin
               zt = longint'($urandom);
            end else begin
               zt = (longint'(sb.eye_q) * 16384) / longint'(sb.cos_q)
                    + longint'(int'($urandom_range(0, 4)) - 2);
               if (zt > 32767) zt = 32767;
               if (zt < -32768) zt = -32768;
            end
            z = zt[15:0];
         end
         default: begin
            // within reach of the eye: mostly on screen
            x = 16'(int'($urandom_range(0, 2 * span)) - span);
            y = 16'(int'($urandom_range(0, 2 * span)) - span);
            z = 16'(int'($urandom_range(0, 2 * span)) - span);
         end
      endcase
   endtask

   task automatic pick_rotation(output logic [15:0] c, output logic [15:0] s);
      real angle;
      angle = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      case ($urandom_range(0, 3))
         0: begin
            // raw register values, no unit-vector relation
            c = 16'($urandom);
            s = 16'($urandom);
         end
         1: begin
            c = 16'(int'($urandom_range(0, 32768)) - 16384);
            s = 16'(int'($urandom_range(0, 32768)) - 16384);
         end
         default: begin
            c = 16'(int'($cos(angle) * 16384.0));
            s = 16'(int'($sin(angle) * 16384.0));
         end
      endcase
   endtask

   function automatic logic [15:0] pick_eye();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return 16'd32767;
         2: return 16'($urandom);
         default: return 16'($urandom_range(64, 4000));
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd255;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic run_phase(input int phase, input logic [15:0] cos_w, input logic [15:0] sin_w,
                            input logic [15:0] eye_w, input logic [15:0] scale_w);
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      configure(cos_w, sin_w, eye_w, scale_w);
      for (int n = 0; n < ItemsPerPhase; n++) begin
         if (phase != QuietPhase && $urandom_range(0, 99) < 8)
            pause_sender($urandom_range(1, 2));
         if (phase == HoldPhase && n == ItemsPerPhase / 2) wait_drained();
         pick_vertex(x, y, z);
         send_vertex(x, y, z);
      end
   endtask

   initial begin
      logic [15:0] rot_c;
      logic [15:0] rot_s;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings (identity rotation, eye 50.0, scale 8.0)
      send_vertex(0, 0, 0);
      send_vertex(16, -16, 0);
      send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000);
      send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
      send_vertex(0, 0, 800);           // denominator exactly zero
      send_vertex(0, 0, 16'sh7FFF);     // far behind the eye
      send_vertex(1600, -1600, 799);    // one-LSB denominator: both saturate
      send_vertex(-1, 1, 0);            // half pixels truncate to zero

      // zero eye distance
      configure(16'hC000, 16'd16384, 16'd0, 16'd255);
      send_corners();
      // trig beyond unit range, zero scale
      configure(16'h8000, 16'h7FFF, 16'd32767, 16'd0);
      send_corners();
      // upper data bits set on the narrow registers
      configure(16'd0, 16'hC000, 16'h8001, 16'hFFFF);
      send_corners();

      // Random phases
      run_phase(0, 16'd16384, 16'd0, 16'd32767, 16'd255);
      run_phase(1, 16'hC000, 16'd16384, 16'd1, 16'd1);
      for (int p = 2; p < NumPhases; p++) begin
         pick_rotation(rot_c, rot_s);
         run_phase(p, rot_c, rot_s, pick_eye(), pick_scale());
      end

      wait_drained();
      repeat (30) @(negedge clock);
      $display("%0d vertex words over %0d register settings, %0d screen words checked",
               vertices_accepted, settings_applied + 1, sb.pixels_checked);
      $display("%0d behind the eye, %0d clipped, %0d mismatches",
               sb.behind_count, sb.clipped_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
         $display("vertex_rotate_project: match");
      else
         $display("vertex_rotate_project: mismatch");
      $finish;
   end

endmodule

// ===== vertex_rotate_project.f =====
src/vrp_pkg.sv
src/vertex_rotate_project.sv
bench/testbench.sv
